@@ rtl/double_ended_queue_macros.svh @@
// Assertion macros for the verification of the double-ended queue.
// Depends on nothing; included by the checker module.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Checks a property on every rising edge of clk while the reset is not held.
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising edge of clk outside reset.
`define DEQ_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/deq_pkg.sv @@
// Shared types and constants of the double-ended queue.
// Depends on nothing; used by every module of the block.
package deq_pkg;

	// Request codes carried in the low bits of the input data.
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_BACK   = 2'd2,
		OP_POP_FRONT  = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RESP = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;      // carry out the accepted request
		logic load_out;  // load the result into the output register
	} cmd_t;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned FILL_W  = 5;
	localparam int unsigned IN_W    = 40;
	localparam int unsigned OUT_W   = 40;
	localparam int unsigned RES_W   = 1 + WORD_W + FILL_W;

endpackage

@@ rtl/deq_ctrl.sv @@
// Controller of the double-ended queue: request handshake and result timing.
// Depends on deq_pkg.
module deq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output deq_pkg::cmd_t cmd
);

	deq_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		s_tready     = 1'b0;
		case (state_q)
			deq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_d  = deq_pkg::ST_RESP;
				end
			end
			deq_pkg::ST_RESP: begin
				// The result waits here until the output register is free.
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = deq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::ST_IDLE;
			end
		endcase
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ rtl/deq_datapath.sv @@
// Datapath of the double-ended queue: ring store, pointers, count and result register.
// Depends on deq_pkg; driven by deq_ctrl.
module deq_datapath #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  deq_pkg::cmd_t              cmd,
	input  logic [deq_pkg::IN_W-1:0]   s_tdata,
	output logic [deq_pkg::OUT_W-1:0]  m_tdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [deq_pkg::WORD_W-1:0] mem [DEPTH];

	logic [AW-1:0] front_q, back_q;
	logic [CW-1:0] count_q;
	logic [deq_pkg::WORD_W-1:0] rd_q;
	logic ok_q, pop_ok_q;
	logic [deq_pkg::RES_W-1:0] out_q;

	deq_pkg::op_t op;
	logic [deq_pkg::WORD_W-1:0] value;
	logic full, empty, do_push_front, do_push_back, do_pop_back, do_pop_front;
	logic mem_we, mem_re;
	logic [AW-1:0] front_prev, front_next, back_prev, back_next, wr_addr, rd_addr;
	logic [CW+deq_pkg::FILL_W-1:0] count_ext;
	logic [deq_pkg::WORD_W-1:0] popped;

	assign op    = deq_pkg::op_t'(s_tdata[deq_pkg::OP_W-1:0]);
	assign value = s_tdata[deq_pkg::OP_W +: deq_pkg::WORD_W];
	assign full  = (count_q == FULL);
	assign empty = (count_q == '0);

	assign front_prev = (front_q == '0)   ? LAST : front_q - AW'(1);
	assign front_next = (front_q == LAST) ? '0   : front_q + AW'(1);
	assign back_prev  = (back_q == '0)    ? LAST : back_q - AW'(1);
	assign back_next  = (back_q == LAST)  ? '0   : back_q + AW'(1);

	always_comb begin
		do_push_front = 1'b0;
		do_push_back  = 1'b0;
		do_pop_back   = 1'b0;
		do_pop_front  = 1'b0;
		case (op)
			deq_pkg::OP_PUSH_FRONT: do_push_front = cmd.exec && !full;
			deq_pkg::OP_PUSH_BACK:  do_push_back  = cmd.exec && !full;
			deq_pkg::OP_POP_BACK:   do_pop_back   = cmd.exec && !empty;
			deq_pkg::OP_POP_FRONT:  do_pop_front  = cmd.exec && !empty;
			default: begin
			end
		endcase
	end

	assign mem_we  = do_push_front || do_push_back;
	assign mem_re  = do_pop_back || do_pop_front;
	assign wr_addr = do_push_front ? front_prev : back_q;
	assign rd_addr = do_pop_back ? back_prev : front_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= value;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push_front) begin
				front_q <= front_prev;
			end else if (do_pop_front) begin
				front_q <= front_next;
			end
			if (do_push_back) begin
				back_q <= back_next;
			end else if (do_pop_back) begin
				back_q <= back_prev;
			end
			if (mem_we) begin
				count_q <= count_q + CW'(1);
			end else if (mem_re) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Status of the request in flight, held until its result is loaded.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q     <= mem_we || mem_re;
			pop_ok_q <= mem_re;
		end
	end

	assign count_ext = {{deq_pkg::FILL_W{1'b0}}, count_q};
	assign popped    = pop_ok_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {count_ext[deq_pkg::FILL_W-1:0], popped, ok_q};
		end
	end

	assign m_tdata = {{(deq_pkg::OUT_W - deq_pkg::RES_W){1'b0}}, out_q};

endmodule

@@ rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue of 32-bit words.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
//   Channel  Direction  Signals                      Contents
//   s_*      in         s_tvalid s_tready s_tdata    one request: op and push_value
//   m_*      out        m_tvalid m_tready m_tdata    one result: ok, popped_value, fill_count
//
// Each request is accepted in ST_IDLE, when the ring store is written or read and
// the pointers and count move; then, in ST_RESP, the registered read data and
// status go into the output register once that register is free.
// A new request is accepted while the previous result still waits in the output
// register; its own result then waits until that register is taken.
// Reset empties the queue at once; the store itself is never cleared, since only
// words written by a push can ever be popped.
module double_ended_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Request channel.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// s_tdata, lowest bit up: op [1:0], push_value [33:2], zero pad [39:34].
	input  logic [deq_pkg::IN_W-1:0]   s_tdata,
	// Result channel.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// m_tdata, lowest bit up: ok [0], popped_value [32:1], fill_count [37:33],
	// zero pad [39:38].
	output logic [deq_pkg::OUT_W-1:0]  m_tdata
);

	// Commands from the controller tell the datapath when to execute a request
	// and when to load its result.
	deq_pkg::cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// The datapath holds the ring store, front and back pointers, word count and
	// output register. A refused push or pop leaves store, pointers, count alone.
	deq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule

@@ rtl/deq_checker.sv @@
// Port-level checker of the double-ended queue and its bind to the top level.
// Depends on deq_pkg and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module deq_checker #(
	parameter int unsigned DEPTH = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [deq_pkg::IN_W-1:0]   s_tdata,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [deq_pkg::OUT_W-1:0]  m_tdata
);

	logic in_fire, in_wait, out_wait, refused_word, fill_high;

	assign in_fire      = s_tvalid && s_tready;
	assign in_wait      = s_tvalid && !s_tready;
	assign out_wait     = m_tvalid && !m_tready;
	assign refused_word = m_tvalid && !m_tdata[0] && (m_tdata[32:1] != '0);
	assign fill_high    = m_tvalid && (DEPTH < 32) && (32'(m_tdata[37:33]) > DEPTH);

	`DEQ_ASSERT(a_out_hold, clk, arst_n, out_wait |=> m_tvalid && $stable(m_tdata), "result moved")
	`DEQ_ASSERT(a_in_hold, clk, arst_n, in_wait |=> s_tvalid && $stable(s_tdata), "request moved")
	`DEQ_ASSERT(a_one_at_a_time, clk, arst_n, in_fire |=> !s_tready, "request while busy")
	`DEQ_NEVER(a_refused_zero, clk, arst_n, refused_word, "refused request returned a word")
	`DEQ_NEVER(a_fill_range, clk, arst_n, fill_high, "fill count above depth")

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
